// File: hw/rtl/unsorted_list_table_defines.svh
`ifndef UNSORTED_LIST_TABLE_DEFINES_SVH
`define UNSORTED_LIST_TABLE_DEFINES_SVH

// next-cycle implication, sampled on clk, off during rst
`define ULT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("unsorted_list_table: implication check failed");

// condition that must never hold, sampled on clk, off during rst
`define ULT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("unsorted_list_table: forbidden condition seen");

`endif

// File: hw/rtl/ult_pkg.sv
package ult_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int LEN_W = 5;
  localparam int ST_W  = 2;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [ST_W-1:0] ST_END    = 2'd3;

  typedef struct packed {
    logic capture;
    logic insert;
    logic delete;
  } cell_cmd_t;

endpackage

// File: hw/rtl/unsorted_list_table.sv
// One result per item; an item is taken only while no earlier item is still busy.
// The input transfer captures the compare of the key against every cell; a later
// edge, once the output register is free, shifts the cell chain and loads the result.
// A stalled result holds the chain until taken; the next item is accepted meanwhile.
// Reset: rst (synchronous, active high) empties the list and rewinds the cursor;
// cell contents are not cleared.
`include "unsorted_list_table_defines.svh"

module unsorted_list_table
  import ult_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // operation[2:0], item_value[34:3], zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // found[0], result_value[32:1],
                                        // list_length[37:33], status[39:38]
);

  logic             busy;
  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] key_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cur_pos;
  logic [CNT_W-1:0] cur_pos_next;
  logic             started;
  logic             started_next;

  logic             found_q;
  logic [VAL_W-1:0] value_q;
  logic [ST_W-1:0]  status_q;
  logic             found_next;
  logic [VAL_W-1:0] value_next;
  logic [ST_W-1:0]  status_next;

  logic             accept;
  logic             go;
  logic             hit;
  logic             not_full;
  logic [CNT_W-1:0] read_pos;
  logic [VAL_W-1:0] key;
  cell_cmd_t        cmd;

  logic [VAL_W-1:0] values [LIST_DEPTH];
  logic             kill   [LIST_DEPTH+1];
  logic             in_range [LIST_DEPTH];

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign go       = busy && (!m_tvalid || m_tready);
  assign key      = busy ? key_q : s_tdata[OP_W +: VAL_W];
  assign hit      = kill[LIST_DEPTH];
  assign not_full = count < CNT_W'(LIST_DEPTH);

  assign cmd.capture = accept;
  assign cmd.insert  = go && (op_q == OP_INSERT) && not_full;
  assign cmd.delete  = go && (op_q == OP_DELETE) && hit;

  assign kill[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_head
      assign left_v = key;
    end else begin : g_body
      assign left_v = values[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_v = values[i];
    end else begin : g_inner
      assign right_v = values[i+1];
    end
    assign in_range[i] = CNT_W'(i) < count;

    ult_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .key         (key),
      .left_value  (left_v),
      .right_value (right_v),
      .in_range    (in_range[i]),
      .kill_in     (kill[i]),
      .value       (values[i]),
      .kill_out    (kill[i+1])
    );
  end

  always_comb begin
    if (!started) begin
      read_pos = '0;
    end else if (cur_pos < CNT_W'(LIST_DEPTH)) begin
      read_pos = cur_pos + CNT_W'(1);
    end else begin
      read_pos = cur_pos;
    end
  end

  always_comb begin
    count_next   = count;
    cur_pos_next = cur_pos;
    started_next = started;
    found_next   = 1'b0;
    value_next   = '0;
    status_next  = ST_OK;
    unique case (op_q)
      OP_CLEAR: begin
        count_next   = '0;
        cur_pos_next = '0;
        started_next = 1'b0;
      end
      OP_INSERT: begin
        if (not_full) begin
          count_next   = count + CNT_W'(1);
          cur_pos_next = '0;
          started_next = 1'b0;
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          found_next = 1'b1;
          value_next = key_q;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          found_next   = 1'b1;
          count_next   = count - CNT_W'(1);
          cur_pos_next = '0;
          started_next = 1'b0;
        end else begin
          status_next = ST_ABSENT;
        end
      end
      OP_REWIND: begin
        cur_pos_next = '0;
        started_next = 1'b0;
      end
      OP_NEXT: begin
        started_next = 1'b1;
        cur_pos_next = read_pos;
        if (read_pos < count) begin
          value_next = values[read_pos[IDX_W-1:0]];
        end else begin
          status_next = ST_END;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      count    <= '0;
      cur_pos  <= '0;
      started  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (go) begin
        busy <= 1'b0;
      end
      if (go) begin
        m_tvalid <= 1'b1;
        count    <= count_next;
        cur_pos  <= cur_pos_next;
        started  <= started_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= s_tdata[OP_W-1:0];
      key_q <= s_tdata[OP_W +: VAL_W];
    end
    if (go) begin
      found_q  <= found_next;
      value_q  <= value_next;
      status_q <= status_next;
    end
  end

  assign m_tdata = {status_q, LEN_W'(count), value_q, found_q};

  `ULT_ASSERT_NEVER(a_count_bound, count > CNT_W'(LIST_DEPTH))
  `ULT_ASSERT_NEVER(a_cursor_bound, cur_pos > CNT_W'(LIST_DEPTH))
  `ULT_ASSERT_NEXT(a_accept_busy, accept, busy)
  `ULT_ASSERT_NEXT(a_go_result, go, m_tvalid)
  `ULT_ASSERT_NEVER(a_shift_excl, cmd.insert && cmd.delete)

endmodule

// File: hw/rtl/ult_cell.sv
module ult_cell
  import ult_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] key,
  input  logic [VAL_W-1:0] left_value,
  input  logic [VAL_W-1:0] right_value,
  input  logic             in_range,
  input  logic             kill_in,
  output logic [VAL_W-1:0] value,
  output logic             kill_out
);

  logic match_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_q <= in_range && (value == key);
    end
    if (cmd.insert) begin
      value <= left_value;
    end else if (cmd.delete && (kill_in || match_q)) begin
      value <= right_value;
    end
  end

  assign kill_out = kill_in | match_q;

endmodule
